@@ rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the button press classifier.
// No dependencies; imported by the interfaces and every module.
package bpc_pkg;

   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic              RST_ACTIVE_LOW      = 1'b1;
   localparam logic [CFG_W-1:0]  RST_DEBOUNCE_MS     = 16'd50;
   localparam logic [CFG_W-1:0]  RST_LONG_PRESS_MS   = 16'd1000;
   localparam logic [CFG_W-1:0]  RST_DOUBLE_WINDOW_MS = 16'd300;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_LOW    = 2'd0,
      CSR_DEBOUNCE      = 2'd1,
      CSR_LONG_PRESS    = 2'd2,
      CSR_DOUBLE_WINDOW = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             pin_invert;
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] long_time;
      logic [CFG_W-1:0] double_window_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              pin_level;
      logic              clear_stats;
   } req_item_type;

   typedef struct packed {
      logic               ev_press_start;
      logic               ev_double;
      logic               ev_long;
      logic               ev_short;
      logic               ev_press_end;
      logic               pressed;
      logic [TIME_W-1:0]  held_ms;
      logic [COUNT_W-1:0] total_count;
      logic [COUNT_W-1:0] short_count;
      logic [COUNT_W-1:0] long_count;
      logic [COUNT_W-1:0] double_count;
   } rsp_item_type;

endpackage

@@ rtl/bpc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample beats, result beats and register writes.
// Depends on bpc_pkg for field widths.
interface bpc_req_if;
   logic                      valid;
   logic                      ready;
   logic [bpc_pkg::TIME_W-1:0] now_ms;
   logic                      pin_level;
   logic                      clear_stats;
   modport source (output valid, output now_ms, output pin_level, output clear_stats,
                   input ready);
   modport sink (input valid, input now_ms, input pin_level, input clear_stats,
                 output ready);
endinterface

interface bpc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ev_press_start;
   logic                        ev_double;
   logic                        ev_long;
   logic                        ev_short;
   logic                        ev_press_end;
   logic                        pressed;
   logic [bpc_pkg::TIME_W-1:0]  held_ms;
   logic [bpc_pkg::COUNT_W-1:0] total_count;
   logic [bpc_pkg::COUNT_W-1:0] short_count;
   logic [bpc_pkg::COUNT_W-1:0] long_count;
   logic [bpc_pkg::COUNT_W-1:0] double_count;
   modport source (output valid, output ev_press_start, output ev_double, output ev_long,
                   output ev_short, output ev_press_end, output pressed, output held_ms,
                   output total_count, output short_count, output long_count,
                   output double_count, input ready);
   modport sink (input valid, input ev_press_start, input ev_double, input ev_long,
                 input ev_short, input ev_press_end, input pressed, input held_ms,
                 input total_count, input short_count, input long_count,
                 input double_count, output ready);
endinterface

interface bpc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bpc_pkg::CSR_IDX_W-1:0]   index;
   logic [bpc_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/bpc_csr.sv @@
`timescale 1ns / 1ps
// Configuration register file: active level, debounce, long and double thresholds.
// Depends on bpc_pkg and bpc_csr_if.
module bpc_csr (
   input  logic              clock,
   input  logic              reset,
   bpc_csr_if.sink           csr_bus,
   output bpc_pkg::cfg_type  cfg
);
   import bpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid && csr_bus.ready;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(csr_bus.index))
            CSR_ACTIVE_LOW:    cfg_in.pin_invert       = csr_bus.data[0];
            CSR_DEBOUNCE:      cfg_in.debounce_time    = csr_bus.data[CFG_W-1:0];
            CSR_LONG_PRESS:    cfg_in.long_time        = csr_bus.data[CFG_W-1:0];
            CSR_DOUBLE_WINDOW: cfg_in.double_window_ms = csr_bus.data[CFG_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_invert       <= RST_ACTIVE_LOW;
         cfg_ff.debounce_time    <= RST_DEBOUNCE_MS;
         cfg_ff.long_time        <= RST_LONG_PRESS_MS;
         cfg_ff.double_window_ms <= RST_DOUBLE_WINDOW_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/bpc_core.sv @@
`timescale 1ns / 1ps
// Debounce and press classification state with its single-pass next-state logic.
// Depends on bpc_pkg; fed by the input register of the top level.
module bpc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bpc_pkg::req_item_type  item,
   input  bpc_pkg::cfg_type       cfg,
   output bpc_pkg::rsp_item_type  result
);
   import bpc_pkg::*;

   logic               stable_ff, stable_in;
   logic               prev_raw_ff, prev_raw_in;
   logic [TIME_W-1:0]  change_stamp_ff, change_stamp_in;
   logic [TIME_W-1:0]  press_stamp_ff, press_stamp_in;
   logic [TIME_W-1:0]  short_stamp_ff, short_stamp_in;
   logic               short_valid_ff, short_valid_in;
   logic               long_rep_ff, long_rep_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] short_cnt_ff, short_cnt_in;
   logic [COUNT_W-1:0] long_cnt_ff, long_cnt_in;
   logic [COUNT_W-1:0] double_cnt_ff, double_cnt_in;

   logic               raw;
   logic               raw_changed;
   logic [TIME_W-1:0]  since_change;
   logic               flip;
   logic               press_rise;
   logic               press_fall;
   logic [TIME_W-1:0]  gap;
   logic               is_double;
   logic [TIME_W-1:0]  press_dur;
   logic               dur_long;
   logic               rel_long;
   logic               rel_short;
   logic [TIME_W-1:0]  hold_time;
   logic               long_rep_base;
   logic               held_long;

   always_comb begin
      raw          = item.pin_level ^ cfg.pin_invert;
      raw_changed  = raw != prev_raw_ff;
      since_change = raw_changed ? '0 : item.now_ms - change_stamp_ff;
      flip         = (since_change > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time})
                     && (raw != stable_ff);
      press_rise   = flip && raw;
      press_fall   = flip && !raw;

      gap       = item.now_ms - short_stamp_ff;
      is_double = press_rise && short_valid_ff
                  && (gap < {{(TIME_W-CFG_W){1'b0}}, cfg.double_window_ms});

      press_dur = item.now_ms - press_stamp_ff;
      dur_long  = press_dur >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_time};
      rel_long  = press_fall && !long_rep_ff && dur_long;
      rel_short = press_fall && !long_rep_ff && !dur_long;

      stable_in     = flip ? raw : stable_ff;
      hold_time     = press_rise ? '0 : press_dur;
      long_rep_base = press_rise ? 1'b0 : long_rep_ff;
      held_long     = stable_in && !long_rep_base
                      && (press_rise ? (cfg.long_time == '0) : dur_long);
      long_rep_in   = long_rep_base | held_long;

      prev_raw_in     = raw;
      change_stamp_in = raw_changed ? item.now_ms : change_stamp_ff;
      press_stamp_in  = press_rise ? item.now_ms : (press_fall ? '0 : press_stamp_ff);

      short_stamp_in = short_stamp_ff;
      short_valid_in = short_valid_ff;
      if (is_double) begin
         short_stamp_in = '0;
         short_valid_in = 1'b0;
      end else if (rel_short) begin
         short_stamp_in = item.now_ms;
         short_valid_in = 1'b1;
      end

      total_in      = (item.clear_stats ? '0 : total_ff)
                      + {{(COUNT_W-1){1'b0}}, press_fall};
      short_cnt_in  = (item.clear_stats ? '0 : short_cnt_ff)
                      + {{(COUNT_W-1){1'b0}}, rel_short};
      long_cnt_in   = (item.clear_stats ? '0 : long_cnt_ff)
                      + {{(COUNT_W-1){1'b0}}, rel_long | held_long};
      double_cnt_in = (item.clear_stats ? '0 : double_cnt_ff)
                      + {{(COUNT_W-1){1'b0}}, is_double};

      result.ev_press_start = press_rise;
      result.ev_double      = is_double;
      result.ev_long        = rel_long | held_long;
      result.ev_short       = rel_short;
      result.ev_press_end   = press_fall;
      result.pressed        = stable_in;
      result.held_ms        = (stable_in && (press_stamp_in != '0)) ? hold_time : '0;
      result.total_count    = total_in;
      result.short_count    = short_cnt_in;
      result.long_count     = long_cnt_in;
      result.double_count   = double_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff       <= 1'b0;
         prev_raw_ff     <= 1'b0;
         change_stamp_ff <= '0;
         press_stamp_ff  <= '0;
         short_stamp_ff  <= '0;
         short_valid_ff  <= 1'b0;
         long_rep_ff     <= 1'b0;
         total_ff        <= '0;
         short_cnt_ff    <= '0;
         long_cnt_ff     <= '0;
         double_cnt_ff   <= '0;
      end else if (advance) begin
         stable_ff       <= stable_in;
         prev_raw_ff     <= prev_raw_in;
         change_stamp_ff <= change_stamp_in;
         press_stamp_ff  <= press_stamp_in;
         short_stamp_ff  <= short_stamp_in;
         short_valid_ff  <= short_valid_in;
         long_rep_ff     <= long_rep_in;
         total_ff        <= total_in;
         short_cnt_ff    <= short_cnt_in;
         long_cnt_ff     <= long_cnt_in;
         double_cnt_ff   <= double_cnt_in;
      end
   end

endmodule

@@ rtl/button_press_classifier_top.sv @@
`timescale 1ns / 1ps
// Button press classifier: each sample beat yields one result beat, one beat per
// cycle sustained while rsp_bus.ready holds. Sample beats land in an input register;
// one pass of compare and 32-bit subtract logic updates the debounce state and writes
// the result register. Register writes are taken every cycle; the user must make them
// only while idle; not enforced. Depends on bpc_pkg, bpc_if, bpc_csr and bpc_core.
module button_press_classifier_top (
   input  logic     clock,
   input  logic     reset,
   bpc_req_if.sink  req_bus,
   bpc_rsp_if.source rsp_bus,
   bpc_csr_if.sink  csr_bus
);
   import bpc_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         req_accept;

   bpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.now_ms      <= req_bus.now_ms;
         in_item_ff.pin_level   <= req_bus.pin_level;
         in_item_ff.clear_stats <= req_bus.clear_stats;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.ev_press_start = rsp_item_ff.ev_press_start;
   assign rsp_bus.ev_double      = rsp_item_ff.ev_double;
   assign rsp_bus.ev_long        = rsp_item_ff.ev_long;
   assign rsp_bus.ev_short       = rsp_item_ff.ev_short;
   assign rsp_bus.ev_press_end   = rsp_item_ff.ev_press_end;
   assign rsp_bus.pressed        = rsp_item_ff.pressed;
   assign rsp_bus.held_ms        = rsp_item_ff.held_ms;
   assign rsp_bus.total_count    = rsp_item_ff.total_count;
   assign rsp_bus.short_count    = rsp_item_ff.short_count;
   assign rsp_bus.long_count     = rsp_item_ff.long_count;
   assign rsp_bus.double_count   = rsp_item_ff.double_count;

   a_start_end_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.ev_press_start && rsp_item_ff.ev_press_end))
      else $error("press start and press end in one beat");

   a_double_on_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.ev_double) |-> rsp_item_ff.ev_press_start)
      else $error("double press without press start");

   a_short_on_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.ev_short)
         |-> (rsp_item_ff.ev_press_end && !rsp_item_ff.ev_long && !rsp_item_ff.pressed))
      else $error("short press outside a release");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input register overwritten while stalled");

endmodule
